// File: src/per_source_packet_rate_limiter_unit_defines.svh
// Assertion macros shared by the rate limiter RTL.
`ifndef PER_SOURCE_PACKET_RATE_LIMITER_UNIT_DEFINES_SVH
`define PER_SOURCE_PACKET_RATE_LIMITER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define PSRL_ASSERT_IMPLIES(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("psrl: same-cycle check failed");
`define PSRL_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("psrl: next-cycle check failed");
`else
`define PSRL_ASSERT_IMPLIES(label, ante, cons)
`define PSRL_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// File: src/psrl_pkg.sv
// Types, constants and the bucket hash of the per-source packet rate limiter.
`default_nettype none

package psrl_pkg;

  localparam int TABLE_ENTRIES   = 4096;
  localparam int WAYS_PER_BUCKET = 4;
  localparam int NUM_BUCKETS     = TABLE_ENTRIES / WAYS_PER_BUCKET;
  localparam int FOLD_BITS       = $clog2(NUM_BUCKETS);
  localparam int BUCKET_W        = (FOLD_BITS > 0) ? FOLD_BITS : 1;
  localparam int FOLD_CHUNKS     = (FOLD_BITS > 0) ? ((32 + FOLD_BITS - 1) / FOLD_BITS) : 1;
  localparam int WAY_W           = (WAYS_PER_BUCKET > 1) ? $clog2(WAYS_PER_BUCKET) : 1;

  localparam logic [15:0] MIN_FRAME_BYTES = 16'd34;
  localparam logic [15:0] ETHERTYPE_IPV4  = 16'h0800;
  localparam logic [7:0]  PROTO_TCP       = 8'd6;
  localparam logic [7:0]  PROTO_UDP       = 8'd17;

  localparam logic [31:0] THRESHOLD_RESET = 32'd5000;
  localparam logic [63:0] WINDOW_RESET    = 64'd1000000000;

  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 64;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_PACKET_THRESHOLD = 1'b0,
    CFG_WINDOW_LENGTH    = 1'b1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    OUT_UNTRACKED = 3'd0,
    OUT_NEW       = 3'd1,
    OUT_RESTART   = 3'd2,
    OUT_UNDER     = 3'd3,
    OUT_OVER      = 3'd4,
    OUT_FULL      = 3'd5
  } outcome_t;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_LOOKUP,
    S_UPDATE
  } state_t;

  typedef struct packed {
    logic [15:0] frame_length;
    logic [15:0] ether_type;
    logic [7:0]  ip_protocol;
    logic [31:0] source_address;
    logic [63:0] arrival_time_ns;
  } in_item_t;

  typedef struct packed {
    logic        drop_packet;
    logic [2:0]  outcome;
    logic [31:0] source_count;
    logic [63:0] drop_total;
  } out_item_t;

  typedef struct packed {
    logic        valid;
    logic [31:0] address;
    logic [63:0] window_start;
    logic [31:0] count;
  } entry_t;

  typedef entry_t [WAYS_PER_BUCKET-1:0] row_t;

  localparam int ROW_W = $bits(row_t);

  function automatic logic [BUCKET_W-1:0] bucket_of(input logic [31:0] addr);
    logic [BUCKET_W-1:0] h;
    logic [31:0]         x;
    h = '0;
    x = addr;
    if (FOLD_BITS == 0) begin
      return '0;
    end
    for (int i = 0; i < FOLD_CHUNKS; i++) begin
      h = h ^ x[BUCKET_W-1:0];
      x = x >> FOLD_BITS;
    end
    if (32'(h) >= 32'(NUM_BUCKETS)) begin
      h = h - BUCKET_W'(NUM_BUCKETS);
    end
    return h;
  endfunction

endpackage

`default_nettype wire

// File: src/psrl_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read port.
`default_nettype none

module psrl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: src/per_source_packet_rate_limiter_unit.sv
// Top level of the per-source packet rate limiter: control, bucket table and result register.
`default_nettype none
`include "per_source_packet_rate_limiter_unit_defines.svh"

// Each item is one packet header summary and yields one result item. An eligible
// item (IPv4, TCP or UDP, at least 34 bytes) passes three steps: acceptance, the
// read of its bucket row from the single bucket memory, and the update that loads
// the result register and, on a hit or a free way, writes the row back. An
// ineligible item skips the read. The update waits while the result register
// still holds an item not yet taken. After reset the table is cleared one bucket
// row per cycle, all NUM_BUCKETS rows (1024 as configured), during which no item
// is accepted; configuration writes are taken at any time.
module per_source_packet_rate_limiter_unit
  import psrl_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire in_item_t               in_data,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output out_item_t                   out_data,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_wdata
);

  state_t              state_r, state_nxt;
  logic [BUCKET_W-1:0] clear_idx_r, clear_idx_nxt;
  logic [31:0]         threshold_r;
  logic [63:0]         window_r;
  logic [63:0]         drop_total_r, drop_total_nxt;
  logic                out_valid_r;
  out_item_t           out_data_r;
  out_item_t           res;
  logic                out_load;

  in_item_t            item_r;
  logic [BUCKET_W-1:0] bucket_r;
  logic                track_r;
  logic                hit_r;
  logic                free_r;
  logic [WAY_W-1:0]    way_r;
  logic [63:0]         elapsed_r;
  logic [31:0]         count_r;

  logic                eligible_in;
  logic                accept;
  logic                ram_we;
  logic [BUCKET_W-1:0] ram_waddr;
  logic [ROW_W-1:0]    ram_wdata;
  logic [ROW_W-1:0]    ram_rdata;
  row_t                rd_row;
  row_t                wr_row;
  entry_t              new_entry;

  logic [WAYS_PER_BUCKET-1:0] match_v;
  logic [WAYS_PER_BUCKET-1:0] free_v;
  logic [WAY_W-1:0]           hit_way;
  logic [WAY_W-1:0]           free_way;
  entry_t                     sel_entry;

  logic                restart;
  logic [31:0]         count_inc;
  logic                over;
  logic                slot_free;

  assign eligible_in = (in_data.frame_length >= MIN_FRAME_BYTES) &&
                       (in_data.ether_type == ETHERTYPE_IPV4) &&
                       ((in_data.ip_protocol == PROTO_TCP) ||
                        (in_data.ip_protocol == PROTO_UDP));
  assign accept = in_valid && in_ready;
  assign rd_row = ram_rdata;

  psrl_ram #(
    .WIDTH (ROW_W),
    .DEPTH (NUM_BUCKETS)
  ) u_bucket_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (accept && eligible_in),
    .raddr (bucket_of(in_data.source_address)),
    .rdata (ram_rdata)
  );

  always_comb begin
    match_v  = '0;
    free_v   = '0;
    hit_way  = '0;
    free_way = '0;
    for (int w = 0; w < WAYS_PER_BUCKET; w++) begin
      match_v[w] = rd_row[w].valid && (rd_row[w].address == item_r.source_address);
      free_v[w]  = !rd_row[w].valid;
    end
    for (int w = WAYS_PER_BUCKET - 1; w >= 0; w--) begin
      if (match_v[w]) begin
        hit_way = WAY_W'(w);
      end
      if (free_v[w]) begin
        free_way = WAY_W'(w);
      end
    end
    sel_entry = rd_row[hit_way];
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r   <= in_data;
      bucket_r <= bucket_of(in_data.source_address);
      track_r  <= eligible_in;
    end
    if (state_r == S_LOOKUP) begin
      hit_r     <= |match_v;
      free_r    <= |free_v;
      way_r     <= (|match_v) ? hit_way : free_way;
      elapsed_r <= item_r.arrival_time_ns - sel_entry.window_start;
      count_r   <= sel_entry.count;
    end
    if (out_load) begin
      out_data_r <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      clear_idx_r  <= '0;
      drop_total_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      clear_idx_r  <= clear_idx_nxt;
      drop_total_r <= drop_total_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r <= THRESHOLD_RESET;
      window_r    <= WINDOW_RESET;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        CFG_PACKET_THRESHOLD: threshold_r <= cfg_wdata[31:0];
        CFG_WINDOW_LENGTH:    window_r    <= cfg_wdata;
        default:              ;
      endcase
    end
  end

  always_comb begin
    state_nxt      = state_r;
    clear_idx_nxt  = clear_idx_r;
    drop_total_nxt = drop_total_r;
    in_ready       = 1'b0;
    ram_we         = 1'b0;
    ram_waddr      = bucket_r;
    ram_wdata      = '0;
    out_load       = 1'b0;
    res            = '0;
    wr_row         = rd_row;
    new_entry      = rd_row[way_r];
    restart        = elapsed_r > window_r;
    count_inc      = (&count_r) ? count_r : count_r + 32'd1;
    over           = count_inc > threshold_r;
    slot_free      = !out_valid_r || out_ready;
    case (state_r)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clear_idx_r;
        if (clear_idx_r == BUCKET_W'(NUM_BUCKETS - 1)) begin
          state_nxt = S_IDLE;
        end else begin
          clear_idx_nxt = clear_idx_r + 1'b1;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_nxt = eligible_in ? S_LOOKUP : S_UPDATE;
        end
      end
      S_LOOKUP: begin
        state_nxt = S_UPDATE;
      end
      S_UPDATE: begin
        if (slot_free) begin
          out_load    = 1'b1;
          state_nxt   = S_IDLE;
          res.outcome = OUT_UNTRACKED;
          if (track_r) begin
            if (hit_r) begin
              ram_we = 1'b1;
              if (restart) begin
                new_entry.window_start = item_r.arrival_time_ns;
                new_entry.count        = 32'd1;
                res.outcome            = OUT_RESTART;
                res.source_count       = 32'd1;
              end else begin
                new_entry.count  = count_inc;
                res.source_count = count_inc;
                if (over) begin
                  res.drop_packet = 1'b1;
                  res.outcome     = OUT_OVER;
                  drop_total_nxt  = drop_total_r + 64'd1;
                end else begin
                  res.outcome = OUT_UNDER;
                end
              end
            end else if (free_r) begin
              ram_we                 = 1'b1;
              new_entry.valid        = 1'b1;
              new_entry.address      = item_r.source_address;
              new_entry.window_start = item_r.arrival_time_ns;
              new_entry.count        = 32'd1;
              res.outcome            = OUT_NEW;
              res.source_count       = 32'd1;
            end else begin
              res.outcome = OUT_FULL;
            end
          end
          wr_row[way_r]  = new_entry;
          ram_wdata      = wr_row;
          res.drop_total = drop_total_nxt;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `PSRL_ASSERT_IMPLIES(a_ram_write_state, ram_we, (state_r == S_CLEAR || state_r == S_UPDATE))
  `PSRL_ASSERT_IMPLIES(a_result_from_update, $rose(out_valid_r), ($past(state_r) == S_UPDATE))
  `PSRL_ASSERT_NEXT(a_update_waits, (state_r == S_UPDATE && out_valid_r && !out_ready), (state_r == S_UPDATE))
  `PSRL_ASSERT_NEXT(a_total_only_on_update, (state_r != S_UPDATE), $stable(drop_total_r))

endmodule

`default_nettype wire
